// ===== design/spl_pkg.sv =====
// Shared constants, codes and types of the sensor piecewise linearizer.
`default_nettype none
package spl_pkg;

    // Default sizes of the calibration store and the sample path.
    localparam int SEGMENTS_DEF    = 20;
    localparam int SENSORS_DEF     = 4;
    localparam int SAMPLE_BITS_DEF = 12;

    // Fixed field widths.
    localparam int DIST_W   = 8;
    localparam int REGION_W = 2;
    localparam int CFG_W    = 8;
    localparam int CFG_IDX_W = 1;

    // Register reset values.
    localparam logic [DIST_W-1:0] NEAR_RESET = 8'd6;
    localparam logic [DIST_W-1:0] FAR_RESET  = 8'd80;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_NEAR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_FAR  = 1'b1;

    // Request command codes.
    localparam logic CMD_CONVERT = 1'b0;
    localparam logic CMD_LOAD    = 1'b1;

    // Result region codes.
    localparam logic [REGION_W-1:0] REGION_LERP = 2'd0;
    localparam logic [REGION_W-1:0] REGION_NEAR = 2'd1;
    localparam logic [REGION_W-1:0] REGION_FAR  = 2'd2;

    // Status of the iterative divider.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage
`default_nettype wire

// ===== design/spl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module spl_ram #(
    parameter int WIDTH  = 20,
    parameter int DEPTH  = 84,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== design/spl_queue.sv =====
// Two-entry queue between the front and the back of the linearizer.
`default_nettype none
module spl_queue #(
    parameter int WIDTH = 32
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    output logic                  o_ready,
    output logic                  o_valid,
    output logic      [WIDTH-1:0] o_data,
    input  wire logic             i_pop
);

    logic [WIDTH-1:0] r_data [2];
    logic             r_wptr;
    logic             r_rptr;
    logic [1:0]       r_count;

    // Entry storage; the payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wptr] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 2'd1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    assign o_ready = (r_count != 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_data  = r_data[r_rptr];

endmodule
`default_nettype wire

// ===== design/spl_div.sv =====
// Restoring divider for unsigned operands, one quotient bit per cycle.
`default_nettype none
module spl_div #(
    parameter int NUM_W = 20,
    parameter int DEN_W = 12
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic        [NUM_W-1:0] i_num,
    input  wire logic        [DEN_W-1:0] i_den,
    output logic             [NUM_W-1:0] o_quo,
    output spl_pkg::t_div_stat           o_stat
);
    import spl_pkg::*;

    localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_sub;
    logic             ge;

    // One trial subtraction of the shifted remainder.
    always_comb begin
        rem_sh  = {r_rem, r_quo[NUM_W-1]};
        rem_sub = rem_sh - {1'b0, r_den};
        ge      = (rem_sh >= {1'b0, r_den});
    end

    // Datapath: the dividend shifts out as the quotient shifts in.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], ge};
        end
    end

    // Step counter and status.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - CNT_W'(1);
                end
            end
        end
    end

    assign o_quo       = r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule
`default_nettype wire

// ===== design/spl_front.sv =====
// Front end: accepts requests, drops invalid ones and forms queue entries.
`default_nettype none
module spl_front #(
    parameter int SEGMENTS    = spl_pkg::SEGMENTS_DEF,
    parameter int SENSORS     = spl_pkg::SENSORS_DEF,
    parameter int SAMPLE_BITS = spl_pkg::SAMPLE_BITS_DEF,
    parameter int SENSOR_W    = (SENSORS > 1) ? $clog2(SENSORS) : 1,
    parameter int POINT_W     = $clog2(SEGMENTS + 1),
    parameter int ADDR_W      = $clog2(SENSORS * (SEGMENTS + 1)),
    parameter int ITEM_W      = 1 + SENSOR_W + ADDR_W + spl_pkg::DIST_W + SAMPLE_BITS
) (
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic                       i_cmd,
    input  wire logic [SENSOR_W-1:0]        i_sensor,
    input  wire logic [POINT_W-1:0]         i_point,
    input  wire logic [spl_pkg::DIST_W-1:0] i_point_distance,
    input  wire logic [SAMPLE_BITS-1:0]     i_point_adc,
    input  wire logic [SAMPLE_BITS-1:0]     i_sample,
    input  wire logic                       i_q_ready,
    output logic                            o_push,
    output logic      [ITEM_W-1:0]          o_item
);
    import spl_pkg::*;

    localparam int POINTS = SEGMENTS + 1;

    logic              sensor_ok;
    logic              point_ok;
    logic              keep;
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] addr;
    logic [SAMPLE_BITS-1:0] data;

    // Classify the request: loads out of range and unknown sensors are dropped.
    always_comb begin
        sensor_ok = (int'(i_sensor) < SENSORS);
        point_ok  = (int'(i_point) <= SEGMENTS);
        keep      = sensor_ok && ((i_cmd == CMD_CONVERT) || point_ok);
        base      = ADDR_W'(int'(i_sensor) * POINTS);
        if (i_cmd == CMD_LOAD) begin
            addr = base + ADDR_W'(i_point);
            data = i_point_adc;
        end else begin
            addr = base;
            data = i_sample;
        end
    end

    assign o_stall = !i_q_ready;
    assign o_push  = i_valid && i_q_ready && keep;
    assign o_item  = {i_cmd, i_sensor, addr, i_point_distance, data};

endmodule
`default_nettype wire

// ===== design/spl_back.sv =====
// Back end: writes calibration points and runs the segment scan and interpolation.
`default_nettype none
module spl_back #(
    parameter int SEGMENTS    = spl_pkg::SEGMENTS_DEF,
    parameter int SENSORS     = spl_pkg::SENSORS_DEF,
    parameter int SAMPLE_BITS = spl_pkg::SAMPLE_BITS_DEF,
    parameter int SENSOR_W    = (SENSORS > 1) ? $clog2(SENSORS) : 1,
    parameter int ADDR_W      = $clog2(SENSORS * (SEGMENTS + 1)),
    parameter int ITEM_W      = 1 + SENSOR_W + ADDR_W + spl_pkg::DIST_W + SAMPLE_BITS
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [spl_pkg::DIST_W-1:0]   i_near,
    input  wire logic [spl_pkg::DIST_W-1:0]   i_far,
    input  wire logic                         i_q_valid,
    input  wire logic [ITEM_W-1:0]            i_q_data,
    output logic                              o_pop,
    output logic                              o_valid,
    input  wire logic                         i_stall,
    output logic      [SENSOR_W-1:0]          o_sensor_out,
    output logic      [spl_pkg::DIST_W-1:0]   o_distance,
    output logic      [spl_pkg::REGION_W-1:0] o_region
);
    import spl_pkg::*;

    localparam int SB     = SAMPLE_BITS;
    localparam int DEPTH  = SENSORS * (SEGMENTS + 1);
    localparam int WORD_W = SB + DIST_W;
    localparam int IDX_W  = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
    localparam int PROD_W = DIST_W + 1 + SB + 1;
    localparam int MAG_W  = DIST_W + SB;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PRIME = 3'd1;
    localparam logic [2:0] S_HI    = 3'd2;
    localparam logic [2:0] S_CMP   = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_DIVGO = 3'd5;
    localparam logic [2:0] S_DIVW  = 3'd6;
    localparam logic [2:0] S_SUM   = 3'd7;

    // Queue entry fields.
    logic                it_load;
    logic [SENSOR_W-1:0] it_sensor;
    logic [ADDR_W-1:0]   it_addr;
    logic [DIST_W-1:0]   it_pdist;
    logic [SB-1:0]       it_data;

    assign it_load   = i_q_data[ITEM_W-1];
    assign it_sensor = i_q_data[ITEM_W-2 -: SENSOR_W];
    assign it_addr   = i_q_data[WORD_W +: ADDR_W];
    assign it_pdist  = i_q_data[SB +: DIST_W];
    assign it_data   = i_q_data[SB-1:0];

    logic [2:0]          r_state;
    logic                r_done;
    logic [ADDR_W-1:0]   r_addr;
    logic [ADDR_W-1:0]   r_end;
    logic [IDX_W-1:0]    r_idx;
    logic [SB-1:0]       r_sample;
    logic [SENSOR_W-1:0] r_sensor;
    logic [SB-1:0]       r_hi_adc;
    logic [DIST_W-1:0]   r_hi_dist;
    logic [DIST_W-1:0]   r_d0;
    logic signed [DIST_W:0] r_ddiff;
    logic [SB-1:0]       r_adiff;
    logic [SB-1:0]       r_den;
    logic signed [PROD_W-1:0] r_prod;
    logic                r_neg;
    logic [DIST_W-1:0]   r_res_dist;
    logic [REGION_W-1:0] r_res_region;
    logic                r_out_valid;
    logic [SENSOR_W-1:0] r_out_sensor;
    logic [DIST_W-1:0]   r_out_dist;
    logic [REGION_W-1:0] r_out_region;

    logic [WORD_W-1:0]   rdata;
    logic [SB-1:0]       rd_adc;
    logic [DIST_W-1:0]   rd_dist;
    logic                ram_we;
    logic                out_free;
    logic                out_load;
    logic                div_start;
    logic [MAG_W-1:0]    div_num;
    logic [MAG_W-1:0]    div_quo;
    t_div_stat           div_stat;
    logic signed [DIST_W+1:0] quo_s;
    logic signed [DIST_W+1:0] sum;

    assign rd_adc  = rdata[WORD_W-1:DIST_W];
    assign rd_dist = rdata[DIST_W-1:0];

    // Calibration store, one word of (ADC value, distance) per point.
    spl_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH),
        .ADDR_W(ADDR_W)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(it_addr),
        .i_wdata({it_data, it_pdist}),
        .i_raddr(r_addr),
        .o_rdata(rdata)
    );

    // Divider for the interpolation quotient.
    spl_div #(
        .NUM_W(MAG_W),
        .DEN_W(SB)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (div_num),
        .i_den  (r_den),
        .o_quo  (div_quo),
        .o_stat (div_stat)
    );

    // Queue pop, store write, divider start and output handoff.
    always_comb begin
        o_pop     = (r_state == S_IDLE) && !r_done && i_q_valid;
        ram_we    = o_pop && (it_load == CMD_LOAD);
        div_start = (r_state == S_DIVGO);
        div_num   = r_prod[PROD_W-1] ? MAG_W'(-r_prod) : MAG_W'(r_prod);
        out_free  = !r_out_valid || !i_stall;
        out_load  = r_done && out_free;
        quo_s     = $signed({2'b00, div_quo[DIST_W-1:0]});
        if (r_neg) begin
            quo_s = -quo_s;
        end
        sum = $signed({2'b00, r_d0}) + quo_s;
    end

    // Scan sequencer and arithmetic.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            if (out_load) begin
                r_done <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_pop && (it_load == CMD_CONVERT)) begin
                        r_addr   <= it_addr;
                        r_end    <= it_addr + ADDR_W'(SEGMENTS);
                        r_sample <= it_data;
                        r_sensor <= it_sensor;
                        r_idx    <= '0;
                        r_state  <= S_PRIME;
                    end
                end
                S_PRIME: begin
                    // First point is being read.
                    if (r_addr != r_end) begin
                        r_addr <= r_addr + ADDR_W'(1);
                    end
                    r_state <= S_HI;
                end
                S_HI: begin
                    r_hi_adc  <= rd_adc;
                    r_hi_dist <= rd_dist;
                    if (r_addr != r_end) begin
                        r_addr <= r_addr + ADDR_W'(1);
                    end
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    // Segment r_idx spans the held upper point and the word read now.
                    if (r_sample > r_hi_adc) begin
                        r_res_dist   <= i_near;
                        r_res_region <= REGION_NEAR;
                        r_done       <= 1'b1;
                        r_state      <= S_IDLE;
                    end else if (r_sample > rd_adc) begin
                        r_d0    <= r_hi_dist;
                        r_ddiff <= $signed({1'b0, rd_dist}) - $signed({1'b0, r_hi_dist});
                        r_adiff <= r_hi_adc - r_sample;
                        r_den   <= r_hi_adc - rd_adc;
                        r_state <= S_MUL;
                    end else if (r_idx == IDX_W'(SEGMENTS - 1)) begin
                        r_res_dist   <= i_far;
                        r_res_region <= REGION_FAR;
                        r_done       <= 1'b1;
                        r_state      <= S_IDLE;
                    end else begin
                        r_hi_adc  <= rd_adc;
                        r_hi_dist <= rd_dist;
                        r_idx     <= r_idx + IDX_W'(1);
                        if (r_addr != r_end) begin
                            r_addr <= r_addr + ADDR_W'(1);
                        end
                    end
                end
                S_MUL: begin
                    r_prod  <= PROD_W'(r_ddiff) * $signed(PROD_W'({1'b0, r_adiff}));
                    r_state <= S_DIVGO;
                end
                S_DIVGO: begin
                    r_neg   <= r_prod[PROD_W-1];
                    r_state <= S_DIVW;
                end
                S_DIVW: begin
                    if (div_stat.done) begin
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    // Quotient truncates toward zero; the sum is kept in 0..255.
                    if (sum < 0) begin
                        r_res_dist <= '0;
                    end else if (sum > $signed(10'd255)) begin
                        r_res_dist <= '1;
                    end else begin
                        r_res_dist <= sum[DIST_W-1:0];
                    end
                    r_res_region <= REGION_LERP;
                    r_done       <= 1'b1;
                    r_state      <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Output register; a finished result waits here while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_sensor <= r_sensor;
            r_out_dist   <= r_res_dist;
            r_out_region <= r_res_region;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_sensor_out = r_out_sensor;
    assign o_distance   = r_out_dist;
    assign o_region     = r_out_region;

endmodule
`default_nettype wire

// ===== design/sensor_piecewise_linearizer.sv =====
// Top level of the sensor piecewise linearizer.
//
// Input channel (i_valid / o_stall): each request either loads one
// calibration point (cmd load) into a sensor's table or converts a raw
// sample (cmd convert) into a distance. Loads give no result. Requests for
// a sensor index of SENSORS or more, and loads of a point beyond SEGMENTS, are dropped.
// Output channel (o_valid / i_stall): one result per convert request, in
// request order, carrying sensor, distance and region.
// Requests pass a two-entry queue to the scan engine, so the front keeps
// taking requests while the engine works and while a result waits.
// A convert reads one point per cycle from the calibration RAM and scans
// the segments in order until one decides on the near or far distance or
// on interpolation; the serial divider (one quotient bit per cycle) then
// forms the quotient and takes the bulk of the time. The engine finishes
// each request before it takes the next one from the queue.
// Reset (synchronous, active low) empties the queue, idles the engine and
// sets near/far distances to 6 and 80; table contents are not cleared.
// While the receiver stalls, the result is held and the engine stops at
// its next finished result; the queue then fills and o_stall rises.
`default_nettype none
module sensor_piecewise_linearizer #(
    parameter int SEGMENTS    = spl_pkg::SEGMENTS_DEF,
    parameter int SENSORS     = spl_pkg::SENSORS_DEF,
    parameter int SAMPLE_BITS = spl_pkg::SAMPLE_BITS_DEF,
    parameter int SENSOR_W    = (SENSORS > 1) ? $clog2(SENSORS) : 1,
    parameter int POINT_W     = $clog2(SEGMENTS + 1)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [spl_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [spl_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic                          i_cmd,
    input  wire logic [SENSOR_W-1:0]           i_sensor,
    input  wire logic [POINT_W-1:0]            i_point,
    input  wire logic [spl_pkg::DIST_W-1:0]    i_point_distance,
    input  wire logic [SAMPLE_BITS-1:0]        i_point_adc,
    input  wire logic [SAMPLE_BITS-1:0]        i_sample,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic      [SENSOR_W-1:0]           o_sensor_out,
    output logic      [spl_pkg::DIST_W-1:0]    o_distance,
    output logic      [spl_pkg::REGION_W-1:0]  o_region
);
    import spl_pkg::*;

    localparam int ADDR_W = $clog2(SENSORS * (SEGMENTS + 1));
    localparam int ITEM_W = 1 + SENSOR_W + ADDR_W + DIST_W + SAMPLE_BITS;

    logic [DIST_W-1:0] r_near;
    logic [DIST_W-1:0] r_far;
    logic              q_ready;
    logic              q_push;
    logic [ITEM_W-1:0] q_in;
    logic              q_valid;
    logic [ITEM_W-1:0] q_out;
    logic              q_pop;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near <= NEAR_RESET;
            r_far  <= FAR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_NEAR: r_near <= i_cfg_data;
                CFG_FAR:  r_far  <= i_cfg_data;
                default:  r_near <= r_near;
            endcase
        end
    end

    // Request intake and classification.
    spl_front #(
        .SEGMENTS   (SEGMENTS),
        .SENSORS    (SENSORS),
        .SAMPLE_BITS(SAMPLE_BITS),
        .SENSOR_W   (SENSOR_W),
        .POINT_W    (POINT_W),
        .ADDR_W     (ADDR_W),
        .ITEM_W     (ITEM_W)
    ) u_front (
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_cmd           (i_cmd),
        .i_sensor        (i_sensor),
        .i_point         (i_point),
        .i_point_distance(i_point_distance),
        .i_point_adc     (i_point_adc),
        .i_sample        (i_sample),
        .i_q_ready       (q_ready),
        .o_push          (q_push),
        .o_item          (q_in)
    );

    // Decoupling queue.
    spl_queue #(
        .WIDTH(ITEM_W)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_data (q_in),
        .o_ready(q_ready),
        .o_valid(q_valid),
        .o_data (q_out),
        .i_pop  (q_pop)
    );

    // Store, scan engine and result register.
    spl_back #(
        .SEGMENTS   (SEGMENTS),
        .SENSORS    (SENSORS),
        .SAMPLE_BITS(SAMPLE_BITS),
        .SENSOR_W   (SENSOR_W),
        .ADDR_W     (ADDR_W),
        .ITEM_W     (ITEM_W)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_near      (r_near),
        .i_far       (r_far),
        .i_q_valid   (q_valid),
        .i_q_data    (q_out),
        .o_pop       (q_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_sensor_out(o_sensor_out),
        .o_distance  (o_distance),
        .o_region    (o_region)
    );

endmodule
`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench for the sensor piecewise linearizer with a predictor and random traffic.
module testbench;
    import spl_pkg::*;

    localparam int SEGMENTS      = SEGMENTS_DEF;
    localparam int SENSORS       = SENSORS_DEF;
    localparam int SAMPLE_BITS   = SAMPLE_BITS_DEF;
    localparam int POINTS        = SEGMENTS + 1;
    localparam int STORE_DEPTH   = SENSORS * POINTS;
    localparam int SENSOR_W      = (SENSORS > 1) ? $clog2(SENSORS) : 1;
    localparam int POINT_W       = $clog2(SEGMENTS + 1);
    localparam int MAX_ADC       = (1 << SAMPLE_BITS) - 1;
    localparam int MAX_POINT_IDX = (1 << POINT_W) - 1;
    localparam int MAX_CM        = (1 << DIST_W) - 1;
    localparam int RANDOM_ITEMS  = 1200;
    localparam int PHASES        = 4;
    localparam int SETTLE_CYCLES = 64;
    localparam int CYCLE_LIMIT   = 1000000;

    typedef struct {
        logic                   cmd;
        logic [SENSOR_W-1:0]    sensor;
        logic [POINT_W-1:0]     point;
        logic [DIST_W-1:0]      point_distance;
        logic [SAMPLE_BITS-1:0] point_adc;
        logic [SAMPLE_BITS-1:0] sample;
    } t_request;

    typedef struct {
        logic [SENSOR_W-1:0] sensor;
        logic [DIST_W-1:0]   distance;
        logic [REGION_W-1:0] region;
    } t_reading;

    typedef enum {TABLE_SMOOTH, TABLE_ROUGH, TABLE_SCRAMBLED} t_table_kind;
    typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} t_stall_mode;

    // Block ports.
    logic                   i_clk;
    logic                   i_rst_n          = 1'b0;
    logic                   i_cfg_we         = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_idx        = CFG_NEAR;
    logic [CFG_W-1:0]       i_cfg_data       = '0;
    logic                   i_valid          = 1'b0;
    logic                   o_stall;
    logic                   i_cmd            = CMD_CONVERT;
    logic [SENSOR_W-1:0]    i_sensor         = '0;
    logic [POINT_W-1:0]     i_point          = '0;
    logic [DIST_W-1:0]      i_point_distance = '0;
    logic [SAMPLE_BITS-1:0] i_point_adc      = '0;
    logic [SAMPLE_BITS-1:0] i_sample         = '0;
    logic                   o_valid;
    logic                   i_stall          = 1'b0;
    logic [SENSOR_W-1:0]    o_sensor_out;
    logic [DIST_W-1:0]      o_distance;
    logic [REGION_W-1:0]    o_region;

    // Predictor state: calibration tables and distance registers.
    logic [SAMPLE_BITS-1:0] table_adc [STORE_DEPTH];
    logic [DIST_W-1:0]      table_cm  [STORE_DEPTH];
    logic [DIST_W-1:0]      near_cm = NEAR_RESET;
    logic [DIST_W-1:0]      far_cm  = FAR_RESET;

    // Stimulus planning shadow: which points are loaded and their ADC values.
    int plan_adc    [STORE_DEPTH];
    bit plan_loaded [STORE_DEPTH];

    t_request request_backlog[$];
    t_reading awaited_readings[$];
    int       mismatches  = 0;
    int       cycle_count = 0;

    // Sender burst and gap counters.
    int burst_left = 0;
    int gap_left   = 0;

    // Receiver stall pattern state.
    t_stall_mode stall_mode      = STALL_NONE;
    int          stall_mode_left = 0;
    int          stall_phase     = 0;

    sensor_piecewise_linearizer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_cmd           (i_cmd),
        .i_sensor        (i_sensor),
        .i_point         (i_point),
        .i_point_distance(i_point_distance),
        .i_point_adc     (i_point_adc),
        .i_sample        (i_sample),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_sensor_out    (o_sensor_out),
        .o_distance      (o_distance),
        .o_region        (o_region)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Expected reading for a sample: scan segments in order until one decides.
    function automatic t_reading linearize(logic [SENSOR_W-1:0] sensor,
                                           logic [SAMPLE_BITS-1:0] sample);
        t_reading r;
        int       base;
        int       a0, a1, d0, d1, est;
        bit       decided;
        base       = int'(sensor) * POINTS;
        r.sensor   = sensor;
        r.distance = far_cm;
        r.region   = REGION_FAR;
        decided    = 1'b0;
        for (int i = 0; i < SEGMENTS && !decided; i++) begin
            a0 = int'(table_adc[base + i]);
            a1 = int'(table_adc[base + i + 1]);
            if (int'(sample) > a0) begin
                r.distance = near_cm;
                r.region   = REGION_NEAR;
                decided    = 1'b1;
            end else if (int'(sample) > a1) begin
                // Signed division truncates toward zero; the divisor is positive here.
                d0  = int'(table_cm[base + i]);
                d1  = int'(table_cm[base + i + 1]);
                est = d0 + ((d1 - d0) * (a0 - int'(sample))) / (a0 - a1);
                if (est < 0) est = 0;
                if (est > MAX_CM) est = MAX_CM;
                r.distance = est[DIST_W-1:0];
                r.region   = REGION_LERP;
                decided    = 1'b1;
            end
        end
        return r;
    endfunction

    // True when converting this sample only reads points that were loaded.
    function automatic bit scan_is_defined(int sensor, int sample);
        int base = sensor * POINTS;
        for (int i = 0; i < SEGMENTS; i++) begin
            if (!plan_loaded[base + i]) return 1'b0;
            if (sample > plan_adc[base + i]) return 1'b1;
            if (!plan_loaded[base + i + 1]) return 1'b0;
            if (sample > plan_adc[base + i + 1]) return 1'b1;
        end
        return 1'b1;
    endfunction

    task automatic queue_load(int sensor, int point, int cm, int adc);
        t_request r;
        r.cmd            = CMD_LOAD;
        r.sensor         = sensor[SENSOR_W-1:0];
        r.point          = point[POINT_W-1:0];
        r.point_distance = cm[DIST_W-1:0];
        r.point_adc      = adc[SAMPLE_BITS-1:0];
        r.sample         = $urandom_range(0, MAX_ADC);
        request_backlog.push_back(r);
        if (point <= SEGMENTS) begin
            plan_adc[sensor * POINTS + point]    = adc;
            plan_loaded[sensor * POINTS + point] = 1'b1;
        end
    endtask

    task automatic queue_convert(int sensor, int sample);
        t_request r;
        r.cmd            = CMD_CONVERT;
        r.sensor         = sensor[SENSOR_W-1:0];
        r.point          = $urandom_range(0, MAX_POINT_IDX);
        r.point_distance = $urandom_range(0, MAX_CM);
        r.point_adc      = $urandom_range(0, MAX_ADC);
        r.sample         = sample[SAMPLE_BITS-1:0];
        request_backlog.push_back(r);
    endtask

    // Loads a whole table. Smooth and rough tables have falling ADC values;
    // rough ones allow flat steps and jumpy distances, scrambled ones are arbitrary.
    task automatic queue_table(int sensor, t_table_kind kind);
        int adc, cm, step_max;
        adc = ($urandom_range(0, 3) == 0) ? MAX_ADC : $urandom_range(2500, MAX_ADC);
        cm  = $urandom_range(0, 40);
        for (int p = 0; p < POINTS; p++) begin
            case (kind)
                TABLE_SMOOTH: begin
                    queue_load(sensor, p, cm, adc);
                end
                TABLE_ROUGH: begin
                    queue_load(sensor, p, $urandom_range(0, MAX_CM), adc);
                end
                default: begin
                    queue_load(sensor, p, $urandom_range(0, MAX_CM),
                               $urandom_range(0, MAX_ADC));
                end
            endcase
            if (p < SEGMENTS) begin
                step_max = adc / (SEGMENTS - p);
                adc -= $urandom_range((kind == TABLE_ROUGH) ? 0 : 1, step_max);
            end
            cm += $urandom_range(0, 12);
            if (cm > MAX_CM) cm = MAX_CM;
        end
    endtask

    // Samples are biased toward table points, the ends of the range and the far side.
    function automatic int pick_sample(int sensor);
        int p, v;
        p = $urandom_range(0, SEGMENTS);
        case ($urandom_range(0, 5))
            0, 1: v = $urandom_range(0, MAX_ADC);
            2, 3: v = plan_adc[sensor * POINTS + p] + int'($urandom_range(0, 2)) - 1;
            4: v = ($urandom_range(0, 1) == 1) ? MAX_ADC : 0;
            default: v = $urandom_range(0, plan_adc[sensor * POINTS + SEGMENTS]);
        endcase
        if (v < 0) v = 0;
        if (v > MAX_ADC) v = MAX_ADC;
        return v;
    endfunction

    // Waits until every request is taken, every reading has come and the engine is quiet.
    task automatic wait_idle();
        do @(negedge i_clk);
        while (request_backlog.size() != 0 || i_valid || awaited_readings.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, int value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value[CFG_W-1:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_NEAR) near_cm = value[DIST_W-1:0];
        else far_cm = value[DIST_W-1:0];
    endtask

    // Random traffic: mostly conversions over loaded tables, with table rebuilds
    // and stray point loads, some of them outside the table.
    task automatic queue_random_phase(int quota, bit rebuild_all);
        int placed, s, p, v, roll;
        t_table_kind kind;
        placed = 0;
        if (rebuild_all) begin
            for (s = 0; s < SENSORS; s++) begin
                queue_table(s, TABLE_SMOOTH);
                placed += POINTS;
            end
        end
        while (placed < quota) begin
            s    = $urandom_range(0, SENSORS - 1);
            roll = $urandom_range(0, 99);
            if (roll < 6) begin
                roll = $urandom_range(0, 19);
                kind = (roll < 12) ? TABLE_SMOOTH : (roll < 17) ? TABLE_ROUGH : TABLE_SCRAMBLED;
                queue_table(s, kind);
                placed += POINTS;
            end else if (roll < 14) begin
                p = $urandom_range(0, MAX_POINT_IDX);
                queue_load(s, p, $urandom_range(0, MAX_CM), $urandom_range(0, MAX_ADC));
                if (p <= SEGMENTS) placed++;
            end else begin
                v = pick_sample(s);
                if (scan_is_defined(s, v)) begin
                    queue_convert(s, v);
                    placed++;
                end else begin
                    queue_table(s, TABLE_SMOOTH);
                    placed += POINTS;
                end
            end
        end
    endtask

    // Driver: presents requests in bursts and updates the predictor on acceptance.
    always @(posedge i_clk) begin
        t_request item;
        int       idx;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                if (i_cmd == CMD_LOAD) begin
                    if (int'(i_point) <= SEGMENTS) begin
                        idx            = int'(i_sensor) * POINTS + int'(i_point);
                        table_adc[idx] = i_point_adc;
                        table_cm[idx]  = i_point_distance;
                    end
                end else begin
                    awaited_readings.push_back(linearize(i_sensor, i_sample));
                end
            end
            if (!i_valid || !o_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (request_backlog.size() > 0) begin
                    item = request_backlog.pop_front();
                    i_valid          <= 1'b1;
                    i_cmd            <= item.cmd;
                    i_sensor         <= item.sensor;
                    i_point          <= item.point;
                    i_point_distance <= item.point_distance;
                    i_point_adc      <= item.point_adc;
                    i_sample         <= item.sample;
                    // A zero gap merges bursts into long stretches without idling.
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted reading and drives the receiver stall pattern.
    always @(posedge i_clk) begin
        t_reading want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (awaited_readings.size() == 0) begin
                $error("unexpected reading: sensor_out %0d distance %0d region %0d",
                       o_sensor_out, o_distance, o_region);
                mismatches++;
            end else begin
                want = awaited_readings.pop_front();
                if (o_sensor_out !== want.sensor) begin
                    $error("sensor_out: expected %0d, got %0d", want.sensor, o_sensor_out);
                    mismatches++;
                end
                if (o_distance !== want.distance) begin
                    $error("distance: expected %0d, got %0d", want.distance, o_distance);
                    mismatches++;
                end
                if (o_region !== want.region) begin
                    $error("region: expected %0d, got %0d", want.region, o_region);
                    mismatches++;
                end
            end
        end
        if (stall_mode_left == 0) begin
            stall_mode      = t_stall_mode'($urandom_range(0, 3));
            stall_mode_left = $urandom_range(20, 200);
        end else begin
            stall_mode_left--;
        end
        stall_phase = (stall_phase == 6) ? 0 : stall_phase + 1;
        case (stall_mode)
            STALL_NONE:  i_stall <= 1'b0;
            STALL_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: i_stall <= ($urandom_range(0, 3) != 0);
            default:     i_stall <= (stall_phase < 3);
        endcase
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("sensor_piecewise_linearizer: mismatch");
            $finish;
        end
    end

    // Sequence: reset, directed cases, then random phases under several settings.
    initial begin
        int near_val, far_val;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Single point, sample above it: near distance.
        queue_load(2, 0, 7, 100);
        queue_convert(2, MAX_ADC);
        queue_convert(2, 101);
        // Full-range segment: both ends and the middle of the interpolation.
        queue_load(3, 0, 0, MAX_ADC);
        queue_load(3, 1, MAX_CM, 0);
        queue_convert(3, MAX_ADC);
        queue_convert(3, 1);
        queue_convert(3, 2048);
        // Falling distance: negative products truncate toward zero.
        queue_load(1, 0, MAX_CM, 3000);
        queue_load(1, 1, 0, 1000);
        queue_convert(1, 1999);
        queue_convert(1, 2999);
        queue_convert(1, 1001);
        // Loads past the last point are dropped and leave the table alone.
        queue_load(3, MAX_POINT_IDX, MAX_CM, MAX_ADC);
        queue_load(3, POINTS, 0, MAX_ADC);
        queue_convert(3, 1);
        // Rising then falling ADC values: 400 scans on to the later segment, 600 is near.
        queue_load(0, 0, 10, 500);
        queue_load(0, 1, 20, 900);
        queue_load(0, 2, 30, 300);
        queue_convert(0, 400);
        queue_convert(0, 600);

        for (int ph = 0; ph < PHASES; ph++) begin
            wait_idle();
            case (ph)
                0: begin
                    near_val = 0;
                    far_val  = MAX_CM;
                end
                1: begin
                    near_val = MAX_CM;
                    far_val  = 0;
                end
                default: begin
                    near_val = $urandom_range(0, MAX_CM);
                    far_val  = $urandom_range(0, MAX_CM);
                end
            endcase
            write_register(CFG_NEAR, near_val);
            write_register(CFG_FAR, far_val);
            queue_random_phase(RANDOM_ITEMS / PHASES, ph == 0);
        end

        wait_idle();
        if (mismatches == 0) begin
            $display("sensor_piecewise_linearizer: match");
        end else begin
            $display("sensor_piecewise_linearizer: mismatch");
        end
        $finish;
    end

endmodule
